// ===== rtl/core/polygon_area_statistics_macros.svh =====
// Assertion macros for the polygon area statistics checker.
`ifndef POLYGON_AREA_STATISTICS_MACROS_SVH
`define POLYGON_AREA_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PAS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("polygon area statistics: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("polygon area statistics: assertion failed");

`endif

// ===== rtl/core/pas_pkg.sv =====
// Shared widths, register indexes and statistic mode codes.
package pas_pkg;

	localparam int COORD_W      = 16;
	localparam int PROD_W       = 2 * COORD_W;
	localparam int ACC_W        = 48;
	localparam int VCNT_W       = 11;
	localparam int MAX_VERTICES = 1024;
	localparam int PCNT_W       = 16;
	localparam int MODE_W       = 4;
	localparam int CFG_DATA_W   = 11;
	localparam int CFG_IDX_W    = 1;
	localparam int DIV_CNT_W    = $clog2(ACC_W);
	localparam int IN_DATA_W    = 2 * COORD_W;

	localparam logic [CFG_IDX_W-1:0] REG_STAT_MODE       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_VERTICES = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_ODD_SUM   = 4'd0,
		MODE_EVEN_SUM  = 4'd1,
		MODE_MEAN      = 4'd2,
		MODE_N_SUM     = 4'd3,
		MODE_MAX_AREA  = 4'd4,
		MODE_MAX_VERTS = 4'd5,
		MODE_MIN_AREA  = 4'd6,
		MODE_MIN_VERTS = 4'd7,
		MODE_ODD_CNT   = 4'd8,
		MODE_EVEN_CNT  = 4'd9,
		MODE_N_CNT     = 4'd10
	} stat_mode_t;

endpackage

// ===== rtl/core/polygon_area_statistics.sv =====
// Polygon area statistics: shoelace area per polygon, one statistic per set.
//
// Input stream: one vertex per word. s_tdata carries coord_x and coord_y,
// s_tlast marks the last vertex of a polygon, s_tuser marks the last word
// of a set. A word with s_tuser high and s_tlast low carries no vertex and
// only ends the set. Output stream: one word per set, m_tdata holds the
// statistic (twice the area, a count or a vertex count) and m_tuser flags
// a mean, max or min asked of an empty set.
// All products go through one 16x16 signed multiplier in S_MUL, with a
// 48-bit adder in S_ACC folding each product into the cross sum.
// A vertex that opens a polygon takes no product, one that continues it
// two, one that closes it up to four and then S_ABS and S_CLOSE; s_tready
// is low meanwhile. A set ends via S_END and S_OUT, and for the mean via
// S_DIV, whose bit-serial divider produces one quotient bit a cycle.
// The result sits in an output register; the block goes back to taking
// vertices while it waits. If the receiver still holds the previous result
// when the next set ends, the block waits until that word is taken.
// Configuration is written through cfg_we, cfg_index and cfg_data while
// the block is idle, which the user must ensure: it is not enforced. Reset
// clears all polygon and set state, picks the odd-polygon sum and target 3.
module polygon_area_statistics (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pas_pkg::IN_DATA_W-1:0]      s_tdata,  // coord_x, coord_y
	input  logic                               s_tlast,  // last_vertex
	input  logic                               s_tuser,  // last_polygon
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pas_pkg::ACC_W-1:0]          m_tdata,  // stat_value
	output logic                               m_tuser,  // empty_error
	input  logic                               cfg_we,
	input  logic [pas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pas_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pas_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ACC, S_POST, S_ABS, S_CLOSE, S_END, S_DIV, S_OUT
	} state_t;

	state_t                     state_q;
	logic [1:0]                 step_q, last_step_q;
	logic signed [COORD_W-1:0]  x_q, y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                       lv_q, lp_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic [ACC_W-1:0]           cross_q, area_q, acc_q, best_q, div_q;
	logic [VCNT_W-1:0]          vcnt_q;
	logic [PCNT_W-1:0]          pcnt_q;
	logic                       seen_q;
	logic [PCNT_W:0]            rem_q;
	logic [DIV_CNT_W-1:0]       div_cnt_q;
	logic [MODE_W-1:0]          stat_mode_q;
	logic [VCNT_W-1:0]          target_q;
	logic                       m_tvalid_q, m_tuser_q;
	logic [ACC_W-1:0]           m_tdata_q;

	logic signed [COORD_W-1:0]  mul_a, mul_b;
	logic [ACC_W-1:0]           prod_ext;
	logic                       has_vertex;
	logic                       is_odd, is_n;
	logic                       add_en, best_en, best_max;
	logic [ACC_W-1:0]           add_val, cand;
	logic [ACC_W:0]             add_sum;
	logic [PCNT_W:0]            rem_sh;
	logic [ACC_W-1:0]           res_value;
	logic                       res_err;

	assign has_vertex = s_tlast || !s_tuser;
	assign prod_ext   = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// Operand order of the four shoelace products; odd steps subtract.
	always_comb begin
		case (step_q)
			2'd0:    begin mul_a = prev_x_q; mul_b = y_q;       end
			2'd1:    begin mul_a = prev_y_q; mul_b = x_q;       end
			2'd2:    begin mul_a = x_q;      mul_b = first_y_q; end
			default: begin mul_a = y_q;      mul_b = first_x_q; end
		endcase
	end

	assign is_odd = vcnt_q[0];
	assign is_n   = (vcnt_q == target_q);

	always_comb begin
		add_en   = 1'b0;
		add_val  = area_q;
		best_en  = 1'b0;
		best_max = 1'b1;
		cand     = area_q;
		case (stat_mode_q)
			MODE_ODD_SUM:   add_en = is_odd;
			MODE_EVEN_SUM:  add_en = !is_odd;
			MODE_MEAN:      add_en = 1'b1;
			MODE_N_SUM:     add_en = is_n;
			MODE_MAX_AREA:  best_en = 1'b1;
			MODE_MAX_VERTS: begin
				best_en = 1'b1;
				cand    = ACC_W'(vcnt_q);
			end
			MODE_MIN_AREA:  begin
				best_en  = 1'b1;
				best_max = 1'b0;
			end
			MODE_MIN_VERTS: begin
				best_en  = 1'b1;
				best_max = 1'b0;
				cand     = ACC_W'(vcnt_q);
			end
			MODE_ODD_CNT:   begin
				add_en  = is_odd;
				add_val = ACC_W'(1);
			end
			MODE_EVEN_CNT:  begin
				add_en  = !is_odd;
				add_val = ACC_W'(1);
			end
			MODE_N_CNT:     begin
				add_en  = is_n;
				add_val = ACC_W'(1);
			end
			default:        ;
		endcase
	end

	assign add_sum = {1'b0, acc_q} + {1'b0, add_val};
	assign rem_sh  = {rem_q[PCNT_W-1:0], div_q[ACC_W-1]};

	always_comb begin
		res_value = '0;
		res_err   = 1'b0;
		case (stat_mode_q)
			MODE_ODD_SUM, MODE_EVEN_SUM, MODE_N_SUM,
			MODE_ODD_CNT, MODE_EVEN_CNT, MODE_N_CNT:
				res_value = acc_q;
			MODE_MEAN: begin
				if (pcnt_q == '0) begin
					res_err = 1'b1;
				end else begin
					res_value = div_q;
				end
			end
			MODE_MAX_AREA, MODE_MAX_VERTS, MODE_MIN_AREA, MODE_MIN_VERTS: begin
				if (!seen_q) begin
					res_err = 1'b1;
				end else begin
					res_value = best_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			last_step_q <= '0;
			x_q         <= '0;
			y_q         <= '0;
			lv_q        <= 1'b0;
			lp_q        <= 1'b0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prod_q      <= '0;
			cross_q     <= '0;
			area_q      <= '0;
			vcnt_q      <= '0;
			acc_q       <= '0;
			pcnt_q      <= '0;
			best_q      <= '0;
			seen_q      <= 1'b0;
			div_q       <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			stat_mode_q <= MODE_W'(MODE_ODD_SUM);
			target_q    <= VCNT_W'(3);
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STAT_MODE:       stat_mode_q <= cfg_data[MODE_W-1:0];
					REG_TARGET_VERTICES: target_q    <= cfg_data[VCNT_W-1:0];
					default:             ;
				endcase
			end

			// In S_OUT the output register is handled by the state itself.
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						x_q  <= s_tdata[COORD_W-1:0];
						y_q  <= s_tdata[IN_DATA_W-1:COORD_W];
						lv_q <= s_tlast;
						lp_q <= s_tuser;
						step_q      <= (vcnt_q == '0) ? 2'd2 : 2'd0;
						last_step_q <= s_tlast ? 2'd3 : 2'd1;
						if (has_vertex && vcnt_q == '0) begin
							first_x_q <= s_tdata[COORD_W-1:0];
							first_y_q <= s_tdata[IN_DATA_W-1:COORD_W];
						end
						if (!has_vertex) begin
							state_q <= S_END;
						end else if (vcnt_q != '0 || s_tlast) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_POST;
						end
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(mul_a) * PROD_W'(mul_b);
					state_q <= S_ACC;
				end
				S_ACC: begin
					cross_q <= step_q[0] ? cross_q - prod_ext : cross_q + prod_ext;
					if (step_q == last_step_q) begin
						state_q <= S_POST;
					end else begin
						step_q  <= step_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_POST: begin
					prev_x_q <= x_q;
					prev_y_q <= y_q;
					if (vcnt_q < VCNT_W'(MAX_VERTICES)) begin
						vcnt_q <= vcnt_q + VCNT_W'(1);
					end
					state_q <= lv_q ? S_ABS : S_IDLE;
				end
				S_ABS: begin
					area_q  <= cross_q[ACC_W-1] ? (~cross_q + ACC_W'(1)) : cross_q;
					state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					if (add_en) begin
						acc_q <= add_sum[ACC_W] ? {ACC_W{1'b1}} : add_sum[ACC_W-1:0];
					end
					if (best_en) begin
						if (!seen_q || (best_max && cand > best_q) ||
								(!best_max && cand < best_q)) begin
							best_q <= cand;
						end
						seen_q <= 1'b1;
					end
					if (pcnt_q != {PCNT_W{1'b1}}) begin
						pcnt_q <= pcnt_q + PCNT_W'(1);
					end
					first_x_q <= '0;
					first_y_q <= '0;
					prev_x_q  <= '0;
					prev_y_q  <= '0;
					cross_q   <= '0;
					vcnt_q    <= '0;
					state_q   <= lp_q ? S_END : S_IDLE;
				end
				S_END: begin
					div_q     <= acc_q;
					rem_q     <= '0;
					div_cnt_q <= '0;
					if (stat_mode_q == MODE_W'(MODE_MEAN) && pcnt_q != '0) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					// Restoring division, one quotient bit per cycle.
					if (rem_sh >= {1'b0, pcnt_q}) begin
						rem_q <= rem_sh - {1'b0, pcnt_q};
						div_q <= {div_q[ACC_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						div_q <= {div_q[ACC_W-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(ACC_W - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_value;
						m_tuser_q  <= res_err;
						first_x_q  <= '0;
						first_y_q  <= '0;
						prev_x_q   <= '0;
						prev_y_q   <= '0;
						cross_q    <= '0;
						vcnt_q     <= '0;
						acc_q      <= '0;
						pcnt_q     <= '0;
						best_q     <= '0;
						seen_q     <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/core/pas_checker.sv =====
// Port-level checker for the polygon area statistics block, with its bind.
`include "polygon_area_statistics_macros.svh"

module pas_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pas_pkg::ACC_W-1:0]     m_tdata,
	input logic                          m_tuser
);
	import pas_pkg::*;

	// Every accepted word makes the block busy, with s_tready low in the next cycle.
	`PAS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// A result word holds until the receiver takes it.
	`PAS_ASSERT_NEXT(a_result_holds, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A new result appears only as the block leaves its busy sequence.
	`PAS_ASSERT_IMPL(a_result_from_busy, clk, arst_n, $rose(m_tvalid), $past(!s_tready))

	// An empty-set error always carries a zero statistic.
	`PAS_ASSERT_IMPL(a_error_zero_value, clk, arst_n, m_tvalid && m_tuser,
		m_tdata == {ACC_W{1'b0}})

endmodule

bind polygon_area_statistics pas_checker u_pas_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/tb_polygon_area_statistics.sv =====
// Self-checking testbench for polygon_area_statistics with a shoelace area predictor.
module tb_polygon_area_statistics;
	timeunit 1ns;
	timeprecision 1ps;

	import pas_pkg::*;

	localparam int LATENCY_WAIT = 80;
	localparam int RANDOM_WORDS = 560;
	localparam int LONG_VERTS   = 100;
	localparam longint CYCLE_LIMIT = 4_000_000;
	localparam logic [MODE_W-1:0] UNUSED_MODE_LO = 4'd11;
	localparam logic [MODE_W-1:0] UNUSED_MODE_HI = 4'd15;
	localparam logic [ACC_W-1:0]  ACC_MAX        = '1;
	localparam int unsigned       POLY_CNT_MAX   = 65535;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [ACC_W-1:0] value;
		logic             empty;
	} stat_word_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;  // coord_x, coord_y
	logic                  s_tlast   = 1'b0; // last_vertex
	logic                  s_tuser   = 1'b0; // last_polygon
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [ACC_W-1:0]      m_tdata;          // stat_value
	logic                  m_tuser;          // empty_error
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Predictor copy of the registers, the open polygon and the set.
	logic [MODE_W-1:0] active_mode;
	logic [VCNT_W-1:0] active_target;
	coord_t            open_x, open_y, last_x, last_y;
	logic [ACC_W-1:0]  shoelace_acc;
	int unsigned       open_vertices;
	logic [ACC_W-1:0]  set_sum;
	int unsigned       closed_polygons;
	logic [ACC_W-1:0]  extreme_value;
	bit                extreme_valid;

	stat_word_t expected_stats[$];

	bit        sender_idle   = 1'b0;
	bit        receiver_idle = 1'b0;
	int        stall_left    = 0;
	int        mismatches    = 0;
	int        stats_checked = 0;
	int        words_sent    = 0;
	int        sets_sent     = 0;
	longint    cycles        = 0;
	bit [15:0] modes_seen    = '0;

	polygon_area_statistics i_dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycles, expected_stats.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: random stall bursts while receiver_idle is set.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 16);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		stat_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_stats.size() == 0) begin
				$display("%0t: result word with nothing expected: value %0d error %0b",
					$time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = expected_stats.pop_front();
				stats_checked++;
				if (m_tdata !== want.value) begin
					$display("%0t: stat_value expected %0d actual %0d",
						$time, want.value, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.empty) begin
					$display("%0t: empty_error expected %0b actual %0b",
						$time, want.empty, m_tuser);
					mismatches++;
				end
			end
		end
	end

	function automatic logic [ACC_W-1:0] add_clamped(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
	endfunction

	function automatic void add_cross_term(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		longint term;
		term = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
		shoelace_acc = shoelace_acc + term[ACC_W-1:0];
	endfunction

	function automatic void clear_polygon();
		open_x = '0;
		open_y = '0;
		last_x = '0;
		last_y = '0;
		shoelace_acc  = '0;
		open_vertices = 0;
	endfunction

	function automatic void clear_set();
		set_sum         = '0;
		closed_polygons = 0;
		extreme_value   = '0;
		extreme_valid   = 1'b0;
	endfunction

	function automatic void close_open_polygon();
		logic [ACC_W-1:0] area;
		logic [ACC_W-1:0] cand;
		bit               odd, hit, take_max, take_min;
		// The cross sum is a signed 48-bit value; its magnitude is twice the area.
		area     = shoelace_acc[ACC_W-1] ? -shoelace_acc : shoelace_acc;
		odd      = open_vertices[0];
		hit      = (open_vertices == active_target);
		cand     = '0;
		take_max = 1'b0;
		take_min = 1'b0;
		case (active_mode)
			MODE_ODD_SUM:   if (odd) set_sum = add_clamped(set_sum, area);
			MODE_EVEN_SUM:  if (!odd) set_sum = add_clamped(set_sum, area);
			MODE_MEAN:      set_sum = add_clamped(set_sum, area);
			MODE_N_SUM:     if (hit) set_sum = add_clamped(set_sum, area);
			MODE_MAX_AREA:  begin cand = area; take_max = 1'b1; end
			MODE_MAX_VERTS: begin cand = ACC_W'(open_vertices); take_max = 1'b1; end
			MODE_MIN_AREA:  begin cand = area; take_min = 1'b1; end
			MODE_MIN_VERTS: begin cand = ACC_W'(open_vertices); take_min = 1'b1; end
			MODE_ODD_CNT:   if (odd) set_sum = add_clamped(set_sum, ACC_W'(1));
			MODE_EVEN_CNT:  if (!odd) set_sum = add_clamped(set_sum, ACC_W'(1));
			MODE_N_CNT:     if (hit) set_sum = add_clamped(set_sum, ACC_W'(1));
			default: ;
		endcase
		if (take_max || take_min) begin
			if (!extreme_valid || (take_max && cand > extreme_value) ||
					(take_min && cand < extreme_value))
				extreme_value = cand;
			extreme_valid = 1'b1;
		end
		if (closed_polygons < POLY_CNT_MAX)
			closed_polygons++;
		clear_polygon();
	endfunction

	function automatic void shoelace_step(input coord_t x, input coord_t y, input bit lv,
			input bit lp, output bit has_stat, output stat_word_t w);
		// A word with last_polygon set and last_vertex clear carries no vertex.
		if (lv || !lp) begin
			if (open_vertices == 0) begin
				open_x = x;
				open_y = y;
			end else begin
				add_cross_term(last_x, last_y, x, y);
			end
			last_x = x;
			last_y = y;
			if (open_vertices < MAX_VERTICES)
				open_vertices++;
			if (lv) begin
				add_cross_term(x, y, open_x, open_y);
				close_open_polygon();
			end
		end
		has_stat = lp;
		w.value  = '0;
		w.empty  = 1'b0;
		if (lp) begin
			modes_seen[active_mode] = 1'b1;
			case (active_mode)
				MODE_ODD_SUM, MODE_EVEN_SUM, MODE_N_SUM,
				MODE_ODD_CNT, MODE_EVEN_CNT, MODE_N_CNT:
					w.value = set_sum;
				MODE_MEAN:
					if (closed_polygons == 0)
						w.empty = 1'b1;
					else
						w.value = set_sum / ACC_W'(closed_polygons);
				MODE_MAX_AREA, MODE_MAX_VERTS, MODE_MIN_AREA, MODE_MIN_VERTS:
					if (!extreme_valid)
						w.empty = 1'b1;
					else
						w.value = extreme_value;
				default: ;
			endcase
			clear_polygon();
			clear_set();
		end
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1:       return coord_t'($urandom_range(0, 200) - 100);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic send_word(input coord_t x, input coord_t y, input bit lv, input bit lp);
		bit         has_stat;
		stat_word_t w;
		s_tdata  <= {y, x};
		s_tlast  <= lv;
		s_tuser  <= lp;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		shoelace_step(x, y, lv, lp, has_stat, w);
		words_sent++;
		if (has_stat) begin
			expected_stats.push_back(w);
			sets_sent++;
		end
		if (sender_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Holds the input off until every result is in and the block has gone quiet.
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_STAT_MODE)
			active_mode = data[MODE_W-1:0];
		else
			active_target = data[VCNT_W-1:0];
	endtask

	task automatic test_reset_defaults();
		// Odd-polygon sum with a target of three, straight out of reset.
		send_word(16'sh8000, 16'sh8000, 1'b0, 1'b0);
		send_word(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
		send_word(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
		send_word(-1, -1, 1'b0, 1'b0);
		send_word(21845, -21846, 1'b0, 1'b0);
		send_word(-21846, 21845, 1'b0, 1'b0);
		send_word(1, 2, 1'b1, 1'b0);
		send_word(16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
		send_word(16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
		send_word(16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
		// This vertex is left open and dropped by the end marker.
		send_word(123, -456, 1'b0, 1'b0);
		send_word(16'sh8000, 16'sh7FFF, 1'b0, 1'b1);
		wait_quiet();
	endtask

	task automatic test_empty_sets();
		cfg_write(REG_STAT_MODE, CFG_DATA_W'(MODE_MEAN));
		send_word(16'sh7FFF, 16'sh8000, 1'b0, 1'b1);
		wait_quiet();
		cfg_write(REG_STAT_MODE, CFG_DATA_W'(MODE_MAX_AREA));
		send_word(0, 0, 1'b0, 1'b1);
		wait_quiet();
		cfg_write(REG_STAT_MODE, CFG_DATA_W'(MODE_MIN_VERTS));
		send_word(5, -7, 1'b0, 1'b0);
		send_word(-3, 9, 1'b0, 1'b0);
		send_word(0, 0, 1'b0, 1'b1);
		wait_quiet();
		cfg_write(REG_STAT_MODE, CFG_DATA_W'(UNUSED_MODE_HI));
		send_word(0, 0, 1'b0, 1'b0);
		send_word(40, 0, 1'b0, 1'b0);
		send_word(0, 40, 1'b1, 1'b1);
		wait_quiet();
	endtask

	task automatic test_mode_change_mid_set();
		// Each polygon folds in under the mode of its closing word; the result
		// uses the mode in force when the set ends.
		cfg_write(REG_STAT_MODE, CFG_DATA_W'(MODE_ODD_SUM));
		send_word(10, 0, 1'b0, 1'b0);
		send_word(0, 10, 1'b0, 1'b0);
		send_word(-7, -3, 1'b1, 1'b0);
		wait_quiet();
		cfg_write(REG_STAT_MODE, CFG_DATA_W'(MODE_EVEN_SUM));
		send_word(-500, -500, 1'b0, 1'b0);
		send_word(500, -500, 1'b0, 1'b0);
		send_word(500, 500, 1'b0, 1'b0);
		send_word(-500, 500, 1'b1, 1'b0);
		wait_quiet();
		cfg_write(REG_STAT_MODE, CFG_DATA_W'(MODE_ODD_CNT));
		send_word(3, 4, 1'b1, 1'b1);
		wait_quiet();
	endtask

	task automatic random_set();
		int unsigned polys, n;
		bit          marker_end;
		polys      = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
		marker_end = (polys == 0) || ($urandom_range(0, 2) == 0);
		for (int p = 0; p < polys; p++) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			for (int v = 0; v < n; v++)
				send_word(rand_coord(), rand_coord(), v == n - 1,
					!marker_end && p == polys - 1 && v == n - 1);
		end
		if (marker_end) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) send_word(rand_coord(), rand_coord(), 1'b0, 1'b0);
			send_word(rand_coord(), rand_coord(), 1'b0, 1'b1);
		end
	endtask

	task automatic test_random_sets();
		int                    start_words, phase;
		logic [MODE_W-1:0]     mode;
		logic [CFG_DATA_W-1:0] word;
		bit                    calm;
		start_words = words_sent;
		phase       = 0;
		while (words_sent - start_words < RANDOM_WORDS) begin
			// The last fifth of the random words runs with no idling at all.
			calm          = (words_sent - start_words) > RANDOM_WORDS * 4 / 5;
			sender_idle   = !calm && $urandom_range(0, 3) != 0;
			receiver_idle = !calm && $urandom_range(0, 3) != 0;
			wait_quiet();
			mode = MODE_W'(phase % 12);
			if (mode == UNUSED_MODE_LO)
				mode = MODE_W'($urandom_range(UNUSED_MODE_LO, UNUSED_MODE_HI));
			// Bits above the mode field are don't-care.
			word              = CFG_DATA_W'($urandom);
			word[MODE_W-1:0]  = mode;
			cfg_write(REG_STAT_MODE, word);
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 5))
					0:       word = '0;
					1:       word = CFG_DATA_W'(MAX_VERTICES);
					default: word = CFG_DATA_W'($urandom_range(1, 8));
				endcase
				cfg_write(REG_TARGET_VERTICES, word);
			end
			repeat ($urandom_range(1, 4)) random_set();
			phase++;
		end
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		wait_quiet();
	endtask

	task automatic test_long_polygons();
		// A long random polygon sets the maximum vertex count.
		cfg_write(REG_STAT_MODE, CFG_DATA_W'(MODE_MAX_VERTS));
		for (int v = 0; v < LONG_VERTS; v++)
			send_word(rand_coord(), rand_coord(), v == LONG_VERTS - 1, 1'b0);
		send_word(1, 1, 1'b1, 1'b1);
		wait_quiet();
		// Winding round the corner box several times builds a large cross sum.
		cfg_write(REG_TARGET_VERTICES, CFG_DATA_W'(LONG_VERTS));
		cfg_write(REG_STAT_MODE, CFG_DATA_W'(MODE_N_SUM));
		for (int v = 0; v < LONG_VERTS; v++)
			send_word((v % 4 == 1 || v % 4 == 2) ? 16'sh7FFF : 16'sh8000,
				(v % 4 >= 2) ? 16'sh7FFF : 16'sh8000,
				v == LONG_VERTS - 1, v == LONG_VERTS - 1);
		wait_quiet();
	endtask

	initial begin
		active_mode   = MODE_ODD_SUM;
		active_target = 3;
		clear_polygon();
		clear_set();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		test_reset_defaults();
		test_empty_sets();
		test_mode_change_mid_set();
		test_random_sets();
		test_long_polygons();
		wait_quiet();
		$display("Sent %0d words in %0d sets over %0d statistic modes, long polygons included.",
			words_sent, sets_sent, $countones(modes_seen));
		$display("Compared %0d set results, %0d mismatches.", stats_checked, mismatches);
		if (mismatches == 0 && expected_stats.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pas_pkg.sv
rtl/core/polygon_area_statistics.sv
rtl/core/pas_checker.sv
tb/tb_polygon_area_statistics.sv
